FILE: rtl/tms_pkg.sv
`timescale 1ns / 1ps
// tms_pkg: shared constants, codes and control structs for the matrix stack.
// Used by tms_ram, tms_mac and transform_matrix_stack_top; depends on nothing.
package tms_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ELEMS       = 16;
    localparam int ELEM_W      = $clog2(ELEMS);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH);
    localparam int ADDR_W      = LEVEL_W + ELEM_W;
    localparam int RAM_DEPTH   = STACK_DEPTH * ELEMS;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int STEP_W      = ELEM_W + 2;

    typedef enum logic [2:0] {
        ACT_LOAD  = 3'd0,
        ACT_PUSH  = 3'd1,
        ACT_POP   = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_READ  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_MAC,
        ST_DRAIN
    } state_t;

    // One multiply-accumulate step travelling down the MAC pipeline.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [ELEM_W-1:0] elem;
    } mac_ctrl_t;

    // One finished product element.
    typedef struct packed {
        logic                     valid;
        logic [ELEM_W-1:0]        elem;
        logic signed [DATA_W-1:0] value;
    } mac_res_t;

endpackage

FILE: rtl/tms_ram.sv
`timescale 1ns / 1ps
// tms_ram: matrix storage, one write port and one registered read port.
// Depends on tms_pkg for depth and widths.
module tms_ram (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [tms_pkg::ADDR_W-1:0]      waddr,
    input  logic [tms_pkg::DATA_W-1:0]      wdata,
    input  logic [tms_pkg::ADDR_W-1:0]      raddr,
    output logic [tms_pkg::DATA_W-1:0]      rdata
);

    logic [tms_pkg::DATA_W-1:0] mem [0:tms_pkg::RAM_DEPTH-1];
    logic [tms_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tms_mac.sv
`timescale 1ns / 1ps
// tms_mac: shared multiply-accumulate unit: multiply, saturating 64-bit
// accumulate, round half up and clamp to Q16.16. Depends on tms_pkg.
module tms_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tms_pkg::mac_ctrl_t               ctrl_in,
    input  logic signed [tms_pkg::DATA_W-1:0] a_in,
    input  logic signed [tms_pkg::DATA_W-1:0] b_in,
    output tms_pkg::mac_res_t                res_out
);

    localparam logic signed [tms_pkg::PROD_W-1:0] ACC_MAX = {1'b0, {(tms_pkg::PROD_W-1){1'b1}}};
    localparam logic signed [tms_pkg::PROD_W-1:0] ACC_MIN = {1'b1, {(tms_pkg::PROD_W-1){1'b0}}};
    localparam logic signed [tms_pkg::DATA_W-1:0] OUT_MAX = {1'b0, {(tms_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [tms_pkg::DATA_W-1:0] OUT_MIN = {1'b1, {(tms_pkg::DATA_W-1){1'b0}}};
    localparam int SH_W = tms_pkg::PROD_W + 1 - 16;

    tms_pkg::mac_ctrl_t                ctrl_p_reg, ctrl_a_reg;
    logic signed [tms_pkg::PROD_W-1:0] prod_reg, acc_reg, acc_next;
    logic signed [tms_pkg::PROD_W:0]   sum_wide, rnd_wide;
    logic signed [SH_W-1:0]            shifted;
    logic signed [tms_pkg::DATA_W-1:0] clamp_next;
    tms_pkg::mac_res_t                 res_reg;

    // Saturating accumulate; first step of an element starts from zero.
    always_comb begin
        sum_wide = {acc_reg[tms_pkg::PROD_W-1], acc_reg}
                 + {prod_reg[tms_pkg::PROD_W-1], prod_reg};
        if (ctrl_p_reg.first) begin
            acc_next = prod_reg;
        end else if (sum_wide[tms_pkg::PROD_W] != sum_wide[tms_pkg::PROD_W-1]) begin
            acc_next = sum_wide[tms_pkg::PROD_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = sum_wide[tms_pkg::PROD_W-1:0];
        end
    end

    // Round half up, floor shift by 16, clamp to 32 bits. Positive overflow
    // of the rounding add would clamp to the 32-bit max anyway.
    always_comb begin
        rnd_wide = {acc_reg[tms_pkg::PROD_W-1], acc_reg} + (tms_pkg::PROD_W+1)'(32768);
        shifted  = rnd_wide[tms_pkg::PROD_W:16];
        if (shifted[SH_W-1:tms_pkg::DATA_W-1] == '0
                || shifted[SH_W-1:tms_pkg::DATA_W-1] == '1) begin
            clamp_next = shifted[tms_pkg::DATA_W-1:0];
        end else begin
            clamp_next = shifted[SH_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_p_reg    <= '0;
            ctrl_a_reg    <= '0;
            res_reg.valid <= 1'b0;
        end else begin
            ctrl_p_reg    <= ctrl_in;
            ctrl_a_reg    <= ctrl_p_reg;
            res_reg.valid <= ctrl_a_reg.valid && ctrl_a_reg.last;
        end
        res_reg.elem  <= ctrl_a_reg.elem;
        res_reg.value <= clamp_next;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_in * b_in;
        acc_reg  <= acc_next;
    end

    assign res_out = res_reg;

endmodule

FILE: rtl/transform_matrix_stack_top.sv
`timescale 1ns / 1ps
// Load, pop, clear, unused codes and refused push reply at once; read waits on the RAM port;
// push onto an empty stack copies the operand (one element copied a cycle); push with
// product: 64 multiply-accumulate steps through the one shared MAC unit plus its pipeline.
// One item at a time: loads stream one per cycle while the sink takes each reply. Reset
// (aresetn, synchronous, active low) empties the stack; matrix memory and operand buffer
// hold unknown data until written, with no clearing pass. Uses tms_pkg/_ram/_mac.
module transform_matrix_stack_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_action,
    input  logic [3:0]                        s_elem_index,
    input  logic signed [31:0]                s_elem_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [3:0]                        m_stack_level,
    output logic signed [31:0]                m_read_value
);

    localparam int LW = tms_pkg::LEVEL_W;
    localparam int EW = tms_pkg::ELEM_W;
    localparam logic [LW-1:0] LEVEL_TOP = LW'(tms_pkg::STACK_DEPTH - 1);
    localparam logic [tms_pkg::STEP_W-1:0] STEP_LAST = '1;
    localparam logic [EW-1:0] ELEM_LAST = '1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tms_pkg::state_t             state_reg, state_next;
    logic [LW-1:0]               level_reg, level_next;
    logic [tms_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [tms_pkg::DATA_W-1:0]  opbuf_reg [0:tms_pkg::ELEMS-1];

    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  m_status_reg;
    logic [3:0]                  m_level_reg;
    logic signed [31:0]          m_value_reg;

    // Response formed by the sequencer; lands in the output register.
    logic                        resp_load;
    tms_pkg::status_t            resp_status;
    logic [LW-1:0]               resp_level;
    logic [tms_pkg::DATA_W-1:0]  resp_value;

    logic                        accept;
    logic                        op_we;
    logic [LW-1:0]               level_dec;

    // RAM ports
    logic                        ram_we;
    logic [tms_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [tms_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

    // MAC feed
    tms_pkg::mac_ctrl_t          issue_ctrl, issue_ctrl_reg;
    logic [tms_pkg::DATA_W-1:0]  b_reg;
    tms_pkg::mac_res_t           mac_res;

    // Output register frees when the sink takes the waiting beat.
    assign s_ready   = (state_reg == tms_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign level_dec = level_reg - LW'(1);

    // ------------------------------------------------------------------
    // Sequencer: next state, level and response
    // ------------------------------------------------------------------
    always_comb begin
        state_next  = state_reg;
        level_next  = level_reg;
        cnt_next    = cnt_reg;
        resp_load   = 1'b0;
        resp_status = tms_pkg::STATUS_OK;
        resp_level  = level_reg;
        resp_value  = '0;
        op_we       = 1'b0;

        case (state_reg)
            tms_pkg::ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    case (s_action)
                        tms_pkg::ACT_LOAD: begin
                            op_we     = 1'b1;
                            resp_load = 1'b1;
                        end
                        tms_pkg::ACT_PUSH: begin
                            if (level_reg >= LEVEL_TOP) begin
                                resp_load   = 1'b1;
                                resp_status = tms_pkg::STATUS_FULL;
                            end else if (level_reg == '0) begin
                                state_next = tms_pkg::ST_COPY;
                            end else begin
                                state_next = tms_pkg::ST_MAC;
                            end
                        end
                        tms_pkg::ACT_POP: begin
                            resp_load = 1'b1;
                            if (level_reg == '0) begin
                                resp_status = tms_pkg::STATUS_EMPTY;
                            end else begin
                                level_next = level_dec;
                                resp_level = level_dec;
                            end
                        end
                        tms_pkg::ACT_CLEAR: begin
                            level_next = '0;
                            resp_level = '0;
                            resp_load  = 1'b1;
                        end
                        tms_pkg::ACT_READ: begin
                            // Empty stack reads zero at once; else wait on the RAM.
                            if (level_reg == '0) begin
                                resp_load = 1'b1;
                            end else begin
                                state_next = tms_pkg::ST_READ;
                            end
                        end
                        default: begin
                            resp_load = 1'b1;
                        end
                    endcase
                end
            end
            tms_pkg::ST_READ: begin
                resp_load  = 1'b1;
                resp_value = ram_rdata;
                state_next = tms_pkg::ST_IDLE;
            end
            tms_pkg::ST_COPY: begin
                // Copy one operand element per cycle into the bottom matrix.
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[EW-1:0] == ELEM_LAST) begin
                    level_next = LW'(1);
                    resp_level = LW'(1);
                    resp_load  = 1'b1;
                    state_next = tms_pkg::ST_IDLE;
                end
            end
            tms_pkg::ST_MAC: begin
                // Issue one multiply-accumulate step per cycle.
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    state_next = tms_pkg::ST_DRAIN;
                end
            end
            tms_pkg::ST_DRAIN: begin
                // Hold until the last product element is written.
                if (mac_res.valid && mac_res.elem == ELEM_LAST) begin
                    level_next = level_reg + LW'(1);
                    resp_level = level_reg + LW'(1);
                    resp_load  = 1'b1;
                    state_next = tms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (resp_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tms_pkg::ST_IDLE;
            level_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload: capture only when a new beat forms.
    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_status_reg <= resp_status;
            m_level_reg  <= 4'(resp_level);
            m_value_reg  <= resp_value;
        end
    end

    // Operand buffer: one element per load beat.
    always_ff @(posedge aclk) begin
        if (op_we) begin
            opbuf_reg[s_elem_index] <= s_elem_value;
        end
    end

    // ------------------------------------------------------------------
    // Matrix memory
    // ------------------------------------------------------------------
    // Step counter in MAC: elem = cnt[5:2] (row, column), k = cnt[1:0].
    always_comb begin
        if (state_reg == tms_pkg::ST_COPY) begin
            ram_we    = 1'b1;
            ram_waddr = {LW'(0), cnt_reg[EW-1:0]};
            ram_wdata = opbuf_reg[cnt_reg[EW-1:0]];
        end else begin
            ram_we    = mac_res.valid;
            ram_waddr = {level_reg, mac_res.elem};
            ram_wdata = mac_res.value;
        end
        if (state_reg == tms_pkg::ST_MAC) begin
            ram_raddr = {level_dec, cnt_reg[5:4], cnt_reg[1:0]};
        end else begin
            ram_raddr = {level_dec, s_elem_index};
        end
    end

    tms_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // MAC feed: align operand element and step control with RAM read data
    // ------------------------------------------------------------------
    always_comb begin
        issue_ctrl.valid = (state_reg == tms_pkg::ST_MAC);
        issue_ctrl.first = (cnt_reg[1:0] == 2'd0);
        issue_ctrl.last  = (cnt_reg[1:0] == 2'd3);
        issue_ctrl.elem  = cnt_reg[5:2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_ctrl_reg <= '0;
        end else begin
            issue_ctrl_reg <= issue_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg <= opbuf_reg[{cnt_reg[1:0], cnt_reg[3:2]}];
    end

    tms_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_in (issue_ctrl_reg),
        .a_in    (ram_rdata),
        .b_in    (b_reg),
        .res_out (mac_res)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_stack_level = m_level_reg;
    assign m_read_value  = m_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_TOP)
        else $error("stack level beyond limit");

    a_mac_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.valid |-> (state_reg == tms_pkg::ST_MAC || state_reg == tms_pkg::ST_DRAIN))
        else $error("product element outside a push");

    a_copy_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tms_pkg::ST_COPY |-> level_reg == '0)
        else $error("copy while stack not empty");

    a_push_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == tms_pkg::ACT_PUSH && level_reg != '0 && level_reg < LEVEL_TOP)
        |=> state_reg == tms_pkg::ST_MAC)
        else $error("product push did not start");

endmodule
